// File: design/cwus_pkg.sv
// ----------------------------------------------------------------------------
// cwus_pkg: shared types and constants for the credit weighted scheduler
// Field widths, function codes, sequencer states and the credit unit
// interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package cwus_pkg;

    localparam int NUM_USERS_DEF = 8;
    localparam int FUNC_W        = 3;
    localparam int USER_W        = 3;
    localparam int AMOUNT_W      = 31;
    localparam int ARRIVAL_W     = 32;
    localparam int CREDIT_W      = 32;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
    localparam logic [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

    typedef enum logic [FUNC_W-1:0] {
        F_LOAD   = 3'd0,
        F_INIT   = 3'd1,
        F_REPL   = 3'd2,
        F_CHARGE = 3'd3,
        F_COMP   = 3'd4,
        F_SETQ   = 3'd5,
        F_SCHED  = 3'd6
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        U_SET,
        U_ADD,
        U_SUB,
        U_REPL
    } t_alu_op;

    typedef struct packed {
        logic cr_gt;
        logic cr_eq;
        logic arr_lt_best;
        logic arr_lt_old;
    } t_cmp;

endpackage

`default_nettype wire

// File: design/cwus_unit.sv
// ----------------------------------------------------------------------------
// cwus_unit: shared credit arithmetic and compare unit
// Saturating set/add/subtract/replenish of one credit, plus the credit and
// arrival compares used by the schedule walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cwus_unit
    import cwus_pkg::*;
(
    input  wire t_alu_op               i_op,
    input  wire logic [CREDIT_W-1:0]   i_credit,
    input  wire logic [AMOUNT_W-1:0]   i_operand,
    input  wire logic [CREDIT_W-1:0]   i_best_cr,
    input  wire logic [ARRIVAL_W-1:0]  i_cand_arr,
    input  wire logic [ARRIVAL_W-1:0]  i_best_arr,
    input  wire logic [ARRIVAL_W-1:0]  i_old_arr,
    output logic [CREDIT_W-1:0]        o_result,
    output t_cmp                       o_cmp
);

    logic [CREDIT_W:0] s_ext_a;
    logic [CREDIT_W:0] s_ext_b;
    logic [CREDIT_W:0] s_sum;
    logic [CREDIT_W:0] s_pick;

    always_comb begin
        s_ext_a = {i_credit[CREDIT_W-1], i_credit};
        s_ext_b = (CREDIT_W+1)'(i_operand);
        s_sum   = (i_op == U_SUB) ? (s_ext_a - s_ext_b) : (s_ext_a + s_ext_b);
        unique case (i_op)
            U_SET:   s_pick = s_ext_b;
            U_REPL:  s_pick = i_credit[CREDIT_W-1] ? s_sum : s_ext_b;
            default: s_pick = s_sum;
        endcase
        // clamp when the sign bit and the guard bit disagree
        if (s_pick[CREDIT_W] != s_pick[CREDIT_W-1]) begin
            o_result = s_pick[CREDIT_W] ? CREDIT_MIN : CREDIT_MAX;
        end else begin
            o_result = s_pick[CREDIT_W-1:0];
        end
    end

    always_comb begin
        o_cmp.cr_gt       = $signed(i_credit) > $signed(i_best_cr);
        o_cmp.cr_eq       = (i_credit == i_best_cr);
        o_cmp.arr_lt_best = (i_cand_arr < i_best_arr);
        o_cmp.arr_lt_old  = (i_cand_arr < i_old_arr);
    end

endmodule

`default_nettype wire

// File: design/credit_weighted_user_scheduler.sv
// ----------------------------------------------------------------------------
// credit_weighted_user_scheduler: per-user credit keeper and picker
// Holds credit, share, waiting flag and arrival per user and serves one
// function per transaction through a sequencer around one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries func, user, amount, pending and
//   arrival; output channel o_valid/i_stall carries credit, found, chosen.
//   Every input transaction yields exactly one output transaction.
//   Init, replenish and schedule walk the users one per cycle through the
//   credit unit and the user tables in ISSUE, then pass DRAIN and register
//   the result in DONE; the next transaction is taken back in IDLE. Charge
//   and compensate read one user in ISSUE, then DRAIN and DONE; load share
//   and set queue go from ISSUE straight to DONE.
//   One transaction is in work at a time; o_stall is high while it runs.
//   A finished result waits in the output register while i_stall is high;
//   a new transaction is taken meanwhile, and the sequencer holds at its
//   final step if the register is still full when its next result is ready.
//   Reset clears credits, shares and waiting flags through per-user valid
//   and waiting bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module credit_weighted_user_scheduler
    import cwus_pkg::*;
#(
    parameter int NUM_USERS = NUM_USERS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [FUNC_W-1:0]           i_func,
    input  wire logic [USER_W-1:0]           i_user,
    input  wire logic [AMOUNT_W-1:0]         i_amount,
    input  wire logic                        i_pending,
    input  wire logic [ARRIVAL_W-1:0]        i_arrival,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic signed [CREDIT_W-1:0]       o_credit,
    output logic                             o_found,
    output logic [USER_W-1:0]                o_chosen
);

    localparam int IW = $clog2(NUM_USERS);
    localparam logic [IW-1:0] LastIdx = IW'(NUM_USERS - 1);

    // user tables
    logic [CREDIT_W-1:0]  r_cr_mem  [NUM_USERS];
    logic [AMOUNT_W-1:0]  r_sh_mem  [NUM_USERS];
    logic [ARRIVAL_W-1:0] r_arr_mem [NUM_USERS];
    logic [NUM_USERS-1:0] r_cr_vb;
    logic [NUM_USERS-1:0] r_sh_vb;
    logic [NUM_USERS-1:0] r_wait;

    // sequencer
    t_state r_state, n_state;
    t_func                 r_func;
    logic [USER_W-1:0]     r_user;
    logic                  r_uvld;
    logic [AMOUNT_W-1:0]   r_amount;
    logic                  r_pending;
    logic [ARRIVAL_W-1:0]  r_arrival;
    logic [IW-1:0]         r_idx;

    // read stage
    logic                  r_p1_vld;
    logic [IW-1:0]         r_p1_idx;
    logic [CREDIT_W-1:0]   r_cr_q;
    logic                  r_cr_vq;
    logic [AMOUNT_W-1:0]   r_sh_q;
    logic                  r_sh_vq;
    logic [ARRIVAL_W-1:0]  r_arr_q;
    logic                  r_wait_q;

    // running results
    logic [CREDIT_W-1:0]   r_res_cr;
    logic                  r_bp_vld;
    logic [CREDIT_W-1:0]   r_bp_cr;
    logic [ARRIVAL_W-1:0]  r_bp_arr;
    logic [IW-1:0]         r_bp_idx;
    logic                  r_bo_vld;
    logic [ARRIVAL_W-1:0]  r_bo_arr;
    logic [IW-1:0]         r_bo_idx;

    // output register
    logic                  r_out_vld;
    logic [CREDIT_W-1:0]   r_o_credit;
    logic                  r_o_found;
    logic [USER_W-1:0]     r_o_chosen;

    logic s_fire;
    logic s_out_free;
    logic s_walk;
    logic s_single;
    logic s_rd;
    logic s_ld_share;
    logic s_setq;
    logic s_out_ld;
    logic s_is_cc;
    logic s_sched;

    logic [CREDIT_W-1:0]  s_cur_cr;
    logic [AMOUNT_W-1:0]  s_cur_sh;
    logic [AMOUNT_W-1:0]  s_operand;
    t_alu_op              s_op;
    logic [CREDIT_W-1:0]  s_result;
    t_cmp                 s_cmp;
    logic                 s_cr_wr;
    logic                 s_cand_pos;
    logic                 s_take_pos;
    logic                 s_take_old;

    assign s_fire     = i_valid && !o_stall;
    assign s_out_free = !r_out_vld || !i_stall;
    assign s_is_cc    = (r_func == F_CHARGE) || (r_func == F_COMP);
    assign s_sched    = (r_func == F_SCHED);
    assign s_walk     = (r_func == F_INIT) || (r_func == F_REPL) || s_sched;
    assign s_single   = s_is_cc && r_uvld;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (s_single || (s_walk && r_idx == LastIdx)) begin
                    n_state = S_DRAIN;
                end else if (!s_walk) begin
                    n_state = S_DONE;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (s_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall    = 1'b1;
        s_rd       = 1'b0;
        s_ld_share = 1'b0;
        s_setq     = 1'b0;
        s_out_ld   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_ISSUE: begin
                s_rd       = s_walk || s_single;
                s_ld_share = (r_func == F_LOAD) && r_uvld;
                s_setq     = (r_func == F_SETQ) && r_uvld;
            end
            S_DRAIN: s_rd = 1'b0;
            S_DONE:  s_out_ld = s_out_free;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // latch the transaction, advance the walk index
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_func    <= t_func'(i_func);
            r_user    <= i_user;
            r_uvld    <= (32'(i_user) < 32'(NUM_USERS));
            r_amount  <= i_amount;
            r_pending <= i_pending;
            r_arrival <= i_arrival;
            r_idx     <= (t_func'(i_func) == F_CHARGE || t_func'(i_func) == F_COMP)
                         ? IW'(i_user) : '0;
        end else if (r_state == S_ISSUE && r_idx != LastIdx) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // table reads, single-user writes and credit write-back
    always_ff @(posedge i_clk) begin
        if (s_rd) begin
            r_cr_q   <= r_cr_mem[r_idx];
            r_cr_vq  <= r_cr_vb[r_idx];
            r_sh_q   <= r_sh_mem[r_idx];
            r_sh_vq  <= r_sh_vb[r_idx];
            r_arr_q  <= r_arr_mem[r_idx];
            r_wait_q <= r_wait[r_idx];
        end
        if (s_ld_share) begin
            r_sh_mem[IW'(r_user)] <= r_amount;
        end
        if (s_setq) begin
            r_arr_mem[IW'(r_user)] <= r_arrival;
        end
        if (s_cr_wr) begin
            r_cr_mem[r_p1_idx] <= s_result;
        end
        r_p1_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr_vb  <= '0;
            r_sh_vb  <= '0;
            r_wait   <= '0;
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= s_rd;
            if (s_ld_share) begin
                r_sh_vb[IW'(r_user)] <= 1'b1;
            end
            if (s_setq) begin
                r_wait[IW'(r_user)] <= r_pending;
            end
            if (s_cr_wr) begin
                r_cr_vb[r_p1_idx] <= 1'b1;
            end
        end
    end

    // process one user per cycle through the shared unit
    always_comb begin
        s_cur_cr  = r_cr_vq ? r_cr_q : '0;
        s_cur_sh  = r_sh_vq ? r_sh_q : '0;
        s_operand = s_is_cc ? r_amount : s_cur_sh;
        priority case (1'b1)
            r_func == F_REPL:   s_op = U_REPL;
            r_func == F_CHARGE: s_op = U_SUB;
            r_func == F_COMP:   s_op = U_ADD;
            default:            s_op = U_SET;
        endcase
        s_cr_wr    = r_p1_vld && !s_sched;
        s_cand_pos = r_wait_q && !s_cur_cr[CREDIT_W-1] && (s_cur_cr != '0);
        s_take_pos = r_p1_vld && s_sched && s_cand_pos &&
                     (!r_bp_vld || s_cmp.cr_gt || (s_cmp.cr_eq && s_cmp.arr_lt_best));
        s_take_old = r_p1_vld && s_sched && r_wait_q && (!r_bo_vld || s_cmp.arr_lt_old);
    end

    cwus_unit u_unit (
        .i_op       (s_op),
        .i_credit   (s_cur_cr),
        .i_operand  (s_operand),
        .i_best_cr  (r_bp_cr),
        .i_cand_arr (r_arr_q),
        .i_best_arr (r_bp_arr),
        .i_old_arr  (r_bo_arr),
        .o_result   (s_result),
        .o_cmp      (s_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp_vld <= 1'b0;
            r_bo_vld <= 1'b0;
        end else if (s_fire) begin
            r_bp_vld <= 1'b0;
            r_bo_vld <= 1'b0;
        end else begin
            if (s_take_pos) begin
                r_bp_vld <= 1'b1;
            end
            if (s_take_old) begin
                r_bo_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_res_cr <= '0;
        end else if (r_p1_vld && s_is_cc) begin
            r_res_cr <= s_result;
        end
        if (s_take_pos) begin
            r_bp_cr  <= s_cur_cr;
            r_bp_arr <= r_arr_q;
            r_bp_idx <= r_p1_idx;
        end
        if (s_take_old) begin
            r_bo_arr <= r_arr_q;
            r_bo_idx <= r_p1_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_out_ld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_ld) begin
            r_o_credit <= r_res_cr;
            r_o_found  <= r_bp_vld || r_bo_vld;
            r_o_chosen <= (r_bp_vld || r_bo_vld)
                          ? USER_W'(r_bp_vld ? r_bp_idx : r_bo_idx) : '0;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_credit = $signed(r_o_credit);
    assign o_found  = r_o_found;
    assign o_chosen = r_o_chosen;

    // ------------------------------------------------------------------------
    a_issue_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state == S_ISSUE))
        else $error("accepted transaction did not start the walk");

    a_read_stage_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> (r_state == S_ISSUE || r_state == S_DRAIN))
        else $error("read stage active outside the walk");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_p1_vld)
        else $error("result loaded before the last user was processed");

    a_best_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bp_vld |-> (!r_bp_cr[CREDIT_W-1] && r_bp_cr != '0))
        else $error("best candidate holds a non-positive credit");

    a_credit_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_credit != '0) |-> !o_found)
        else $error("credit and found reported together");

endmodule

`default_nettype wire
